// File: rtl/core/cjt_pkg.sv
package cjt_pkg;

   // Fixed-point format of angles, velocities and times.
   localparam int FRAC_BITS = 16;

   // Divider works on a magnitude shifted up by the fraction bits.
   localparam int DVD_W = 64 + FRAC_BITS;
   localparam int CNT_W = $clog2(DVD_W);

   localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
   localparam logic signed [31:0] S32_MAX = {1'b0, {31{1'b1}}};
   localparam logic signed [31:0] S32_MIN = {1'b1, {31{1'b0}}};

   // Request actions.
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_DIV_END,
      ST_SETUP,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACC,
      ST_EMIT
   } state_type;

   // Division chain of a load: two divisions of 3D, one of 2v0+v1,
   // three of 2D and two of v0+v1.
   typedef enum logic [2:0] {
      LD_3D_A,
      LD_3D_B,
      LD_VB,
      LD_2D_A,
      LD_2D_B,
      LD_2D_C,
      LD_VS_A,
      LD_VS_B
   } load_step_type;

   typedef enum logic [1:0] {
      HS_QUAD,
      HS_LIN,
      HS_CONST
   } horner_step_type;

endpackage

// File: rtl/core/cubic_joint_trajectory_core.sv
// Cubic joint trajectory core. A load beat (action 0) stores the cubic coefficients of one
// joint from its start and goal angle and velocity and the duration register; it returns
// nothing and keeps the core busy while the bit-serial restoring divider runs the eight
// chained divisions by the duration (a zero duration skips them and sets the quadratic and
// cubic coefficients to zero). An evaluate beat (action 1) returns one position beat per
// joint in joint order, the last one marked (Horner form on one shared 32 x 32 multiplier:
// per coefficient a setup step, two multiplier passes and one add, then the beat is
// emitted), and it waits while the result side stalls.
// Write the duration only while the core is idle, then load all joints again.
module cubic_joint_trajectory_core
   import cjt_pkg::*;
#(
   parameter int JOINT_COUNT = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic [2:0]          req_joint,
   input  logic signed [31:0]  req_start_angle,
   input  logic signed [31:0]  req_start_velocity,
   input  logic signed [31:0]  req_goal_angle,
   input  logic signed [31:0]  req_goal_velocity,
   input  logic [31:0]         req_time_req,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_joint_out,
   output logic signed [31:0]  rsp_position,
   output logic                rsp_saturated,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [31:0]         csr_duration
);

   localparam int IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(JOINT_COUNT - 1);

   // Saturating signed additions and subtractions.
   function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? S64_MIN : S64_MAX;
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? S64_MIN : S64_MAX;
      end
      return s[63:0];
   endfunction

   function automatic logic [63:0] abs64(input logic signed [63:0] x);
      return x[63] ? 64'(-x) : 64'(x);
   endfunction

   // Dividend that opens a stage of the load division chain.
   function automatic logic signed [63:0] load_src(input load_step_type st,
                                                   input logic signed [31:0] s,
                                                   input logic signed [31:0] v0,
                                                   input logic signed [31:0] g,
                                                   input logic signed [31:0] v1);
      logic signed [63:0] d;
      logic signed [63:0] ve0;
      logic signed [63:0] ve1;
      d   = 64'(g) - 64'(s);
      ve0 = 64'(v0);
      ve1 = 64'(v1);
      case (st)
         LD_3D_A: return (d <<< 1) + d;
         LD_VB:   return (ve0 <<< 1) + ve1;
         LD_2D_A: return d <<< 1;
         LD_VS_A: return ve0 + ve1;
         default: return '0;
      endcase
   endfunction

   state_type           state_ff, state_in;
   load_step_type       step_ff, step_in;
   horner_step_type     hstep_ff, hstep_in;
   logic [IDX_W-1:0]    jidx_ff, jidx_in;
   logic [31:0]         duration_ff;
   logic signed [31:0]  s_ff, v0_ff, g_ff, v1_ff;
   logic [31:0]         time_ff;
   logic                neg_ff, neg_in;
   logic [DVD_W-1:0]    dvd_ff, dvd_in;
   logic [31:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [63:0]         mag_ff, mag_in;
   logic [63:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic signed [63:0]  acc_ff, acc_in;
   logic signed [63:0]  tmp_ff, tmp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_joint_ff;
   logic signed [31:0]  rsp_pos_ff;
   logic                rsp_sat_ff, rsp_last_ff;
   logic                emit_go;
   logic signed [31:0]  emit_pos;
   logic                emit_sat;

   logic signed [31:0]  c0_ff [JOINT_COUNT];
   logic signed [31:0]  c1_ff [JOINT_COUNT];
   logic signed [63:0]  c2_ff [JOINT_COUNT];
   logic signed [63:0]  c3_ff [JOINT_COUNT];

   logic                req_take, load_take, load_ok;
   logic                c01_we, c2_we, c3_we;
   logic signed [63:0]  c2_wd, c3_wd;
   logic                div_go, mul_go;
   logic signed [63:0]  div_x, mul_x;
   logic [32:0]         div_sh;
   logic                div_bit;
   logic signed [63:0]  div_res;
   logic [95:0]         mul_full;
   logic [95:0]         mul_shr;
   logic signed [63:0]  mul_res;
   logic signed [63:0]  addend;
   logic signed [63:0]  horner_p;
   logic [31:0]         mult_a;
   logic [63:0]         mult_p;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign load_take = req_take && (req_action == ACT_LOAD);
   assign load_ok   = 32'(req_joint) < JOINT_COUNT;
   assign csr_ready = 1'b1;

   // One restoring divide step per cycle on the duration.
   assign div_sh  = {rem_ff, dvd_ff[DVD_W-1]};
   assign div_bit = div_sh >= {1'b0, duration_ff};

   // Signed, saturated quotient once the divider has run all bits.
   always_comb begin
      if (|dvd_ff[DVD_W-1:63]) begin
         div_res = neg_ff ? S64_MIN : S64_MAX;
      end else if (neg_ff) begin
         div_res = -$signed({1'b0, dvd_ff[62:0]});
      end else begin
         div_res = $signed({1'b0, dvd_ff[62:0]});
      end
   end

   // Shared multiplier: low half of the magnitude first, then the high half.
   assign mult_a = (state_ff == ST_MUL_LO) ? mag_ff[31:0] : mag_ff[63:32];
   assign mult_p = 64'(mult_a) * 64'(time_ff);

   // Recombine both partial products, scale down and saturate.
   assign mul_full = {hi_ff, 32'b0} + {32'b0, lo_ff};
   assign mul_shr  = mul_full >> FRAC_BITS;
   always_comb begin
      if (|mul_shr[95:63]) begin
         mul_res = neg_ff ? S64_MIN : S64_MAX;
      end else if (neg_ff) begin
         mul_res = -$signed({1'b0, mul_shr[62:0]});
      end else begin
         mul_res = $signed({1'b0, mul_shr[62:0]});
      end
   end

   always_comb begin
      case (hstep_ff)
         HS_QUAD: addend = c2_ff[jidx_ff];
         HS_LIN:  addend = 64'(c1_ff[jidx_ff]);
         default: addend = 64'(c0_ff[jidx_ff]);
      endcase
   end
   assign horner_p = add_sat(mul_res, addend);

   // Clip the final position to 32 bits.
   always_comb begin
      if (acc_ff > 64'(S32_MAX)) begin
         emit_pos = S32_MAX;
         emit_sat = 1'b1;
      end else if (acc_ff < 64'(S32_MIN)) begin
         emit_pos = S32_MIN;
         emit_sat = 1'b1;
      end else begin
         emit_pos = acc_ff[31:0];
         emit_sat = 1'b0;
      end
   end

   // Sequencer: next state and datapath controls.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      hstep_in = hstep_ff;
      jidx_in  = jidx_ff;
      neg_in   = neg_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      mag_in   = mag_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      acc_in   = acc_ff;
      tmp_in   = tmp_ff;
      c01_we   = 1'b0;
      c2_we    = 1'b0;
      c3_we    = 1'b0;
      c2_wd    = '0;
      c3_wd    = '0;
      div_go   = 1'b0;
      div_x    = '0;
      mul_go   = 1'b0;
      mul_x    = '0;
      emit_go  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_action == ACT_EVAL)) begin
               jidx_in  = '0;
               hstep_in = HS_QUAD;
               state_in = ST_SETUP;
            end else if (load_take && load_ok) begin
               jidx_in = IDX_W'(req_joint);
               c01_we  = 1'b1;
               if (duration_ff == '0) begin
                  c2_we = 1'b1;
                  c3_we = 1'b1;
               end else begin
                  step_in  = LD_3D_A;
                  div_go   = 1'b1;
                  div_x    = load_src(LD_3D_A, req_start_angle, req_start_velocity,
                                      req_goal_angle, req_goal_velocity);
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in = div_bit ? 32'(div_sh - {1'b0, duration_ff}) : div_sh[31:0];
            dvd_in = {dvd_ff[DVD_W-2:0], div_bit};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END: begin
            div_go   = 1'b1;
            div_x    = div_res;
            state_in = ST_DIV;
            step_in  = load_step_type'(step_ff + 1'b1);
            case (step_ff)
               LD_3D_B: begin
                  tmp_in = div_res;
                  div_x  = load_src(LD_VB, s_ff, v0_ff, g_ff, v1_ff);
               end
               LD_VB: begin
                  c2_we = 1'b1;
                  c2_wd = sub_sat(tmp_ff, div_res);
                  div_x = load_src(LD_2D_A, s_ff, v0_ff, g_ff, v1_ff);
               end
               LD_2D_C: begin
                  tmp_in = div_res;
                  div_x  = load_src(LD_VS_A, s_ff, v0_ff, g_ff, v1_ff);
               end
               LD_VS_B: begin
                  c3_we    = 1'b1;
                  c3_wd    = sub_sat(div_res, tmp_ff);
                  div_go   = 1'b0;
                  state_in = ST_IDLE;
               end
               default: begin
               end
            endcase
         end
         ST_SETUP: begin
            // The first pass of a joint multiplies a3, later passes the running sum.
            mul_go   = 1'b1;
            mul_x    = (hstep_ff == HS_QUAD) ? c3_ff[jidx_ff] : acc_ff;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            lo_in    = mult_p;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            hi_in    = mult_p;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = horner_p;
            if (hstep_ff == HS_CONST) begin
               state_in = ST_EMIT;
            end else begin
               hstep_in = horner_step_type'(hstep_ff + 1'b1);
               state_in = ST_SETUP;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               emit_go = 1'b1;
               if (jidx_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  jidx_in  = jidx_ff + 1'b1;
                  hstep_in = HS_QUAD;
                  state_in = ST_SETUP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (div_go) begin
         neg_in = div_x[63];
         dvd_in = {abs64(div_x), {FRAC_BITS{1'b0}}};
         rem_in = '0;
         cnt_in = CNT_W'(DVD_W - 1);
      end
      if (mul_go) begin
         neg_in = mul_x[63];
         mag_in = abs64(mul_x);
      end
   end

   // Output register valid.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   // State register and control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= LD_3D_A;
         hstep_ff     <= HS_QUAD;
         jidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         duration_ff  <= 32'd65536;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         hstep_ff     <= hstep_in;
         jidx_ff      <= jidx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            duration_ff <= csr_duration;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      acc_ff <= acc_in;
      tmp_ff <= tmp_in;
      if (req_take) begin
         s_ff    <= req_start_angle;
         v0_ff   <= req_start_velocity;
         g_ff    <= req_goal_angle;
         v1_ff   <= req_goal_velocity;
         time_ff <= req_time_req;
      end
      if (emit_go) begin
         rsp_joint_ff <= 3'(jidx_ff);
         rsp_pos_ff   <= emit_pos;
         rsp_sat_ff   <= emit_sat;
         rsp_last_ff  <= (jidx_ff == LAST_IDX);
      end
   end

   // Per-joint coefficient store, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < JOINT_COUNT; i++) begin
            c0_ff[i] <= '0;
            c1_ff[i] <= '0;
            c2_ff[i] <= '0;
            c3_ff[i] <= '0;
         end
      end else begin
         if (c01_we) begin
            c0_ff[jidx_in] <= req_start_angle;
            c1_ff[jidx_in] <= req_start_velocity;
         end
         if (c2_we) begin
            c2_ff[jidx_in] <= c2_wd;
         end
         if (c3_we) begin
            c3_ff[jidx_in] <= c3_wd;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_joint_out = rsp_joint_ff;
   assign rsp_position  = rsp_pos_ff;
   assign rsp_saturated = rsp_sat_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   // The last beat of a run carries the highest joint index.
   a_last_joint: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_joint_out == 3'(JOINT_COUNT - 1)))
      else $error("last flag on a joint other than the highest");

   // Checks that the divider only runs with a nonzero duration.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (duration_ff != '0))
      else $error("divider running on a zero duration");

   // A load never starts a result beat.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_action == ACT_LOAD)) |=> !$rose(rsp_valid))
      else $error("load produced a result beat");
`endif

endmodule
